/* hw/rtl/tcwr_pkg.sv */
// Shared constants and widths for the windowed tip counter and rate meter.
`default_nettype none
package tcwr_pkg;
    localparam int RING_DEPTH_DEF = 64;

    localparam int TIME_W  = 32;
    localparam int TIPS_W  = 31;
    localparam int Q16_W   = 48;
    localparam int ACC_W   = 56;
    localparam int MULA_W  = 32;
    localparam int MULB_W  = 24;
    localparam int CHUNK_W = 28;
    localparam int NUM_W   = 72;
    localparam int DEN_W   = 33;
    localparam int CNT_W   = 7;
    localparam int CFG_W   = 24;

    localparam logic [1:0] CMD_PIN   = 2'd0;
    localparam logic [1:0] CMD_TICK  = 2'd1;
    localparam logic [1:0] CMD_RESET = 2'd2;

    localparam logic [1:0] REG_DEBOUNCE = 2'd0;
    localparam logic [1:0] REG_WINDOW   = 2'd1;
    localparam logic [1:0] REG_ML       = 2'd2;
    localparam logic [1:0] REG_AREA     = 2'd3;

    localparam logic [MULB_W-1:0] K_RATE   = 24'd60000;
    localparam logic [MULB_W-1:0] K_RAINMM = 24'd2560;
    localparam logic [MULB_W-1:0] K_RATEMM = 24'd153600;

    localparam logic [Q16_W-1:0] SAT48 = {Q16_W{1'b1}};

    localparam logic [CNT_W-1:0] DIV_LAST = CNT_W'(NUM_W - 1);
endpackage
`default_nettype wire

/* hw/rtl/tcwr_div.sv */
// Bit-serial restoring divider with a 48-bit saturated quotient.
`default_nettype none
module tcwr_div
(
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        start,
    input  wire logic [tcwr_pkg::NUM_W-1:0]  num,
    input  wire logic [tcwr_pkg::DEN_W-1:0]  den,
    output logic                             done,
    output logic [tcwr_pkg::Q16_W-1:0]       quot
);
    logic                           busy_reg, busy_next;
    logic                           done_reg, done_next;
    logic [tcwr_pkg::CNT_W-1:0]     cnt_reg, cnt_next;
    logic [tcwr_pkg::DEN_W-1:0]     rem_reg, rem_next;
    logic [tcwr_pkg::NUM_W-1:0]     nq_reg, nq_next;
    logic [tcwr_pkg::DEN_W:0]       trial;
    logic                           fits;

    // One quotient bit per cycle; the numerator register collects the quotient.
    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        nq_next   = nq_reg;
        trial     = {rem_reg, nq_reg[tcwr_pkg::NUM_W-1]};
        fits      = (trial >= {1'b0, den});
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            rem_next  = '0;
            nq_next   = num;
        end
        else if (busy_reg)
        begin
            rem_next = fits ? tcwr_pkg::DEN_W'(trial - {1'b0, den})
                            : trial[tcwr_pkg::DEN_W-1:0];
            nq_next  = {nq_reg[tcwr_pkg::NUM_W-2:0], fits};
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == tcwr_pkg::DIV_LAST)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        nq_reg  <= nq_next;
    end

    assign done = done_reg;
    assign quot = (|nq_reg[tcwr_pkg::NUM_W-1:tcwr_pkg::Q16_W]) ? tcwr_pkg::SAT48
                                                               : nq_reg[tcwr_pkg::Q16_W-1:0];
endmodule
`default_nettype wire

/* hw/rtl/tcwr_ring.sv */
// Sample ring memory holding a timestamp and tip count per entry.
`default_nettype none
module tcwr_ring
#(
    parameter int DEPTH = tcwr_pkg::RING_DEPTH_DEF
)
(
    input  wire logic                                         clk,
    input  wire logic                                         we,
    input  wire logic [$clog2(DEPTH)-1:0]                     waddr,
    input  wire logic [tcwr_pkg::TIPS_W+tcwr_pkg::TIME_W-1:0] wdata,
    input  wire logic [$clog2(DEPTH)-1:0]                     raddr,
    output logic [tcwr_pkg::TIPS_W+tcwr_pkg::TIME_W-1:0]      rdata
);
    logic [tcwr_pkg::TIPS_W+tcwr_pkg::TIME_W-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule
`default_nettype wire

/* hw/rtl/tip_counter_windowed_rate_top.sv */
// Top level of the tipping-bucket pulse counter with a windowed rate meter.
// A pin event, undefined command or session reset with no area set goes straight to the output;
// a tick first walks the ring entries inside the window (up to RING_DEPTH entries), and each
// command may then run up to three divisions in the shared divider.
// Throughput: one command at a time; the next transfer is taken once the result is taken.
// Reset clears counters, ring pointers and held rate; registers take their defaults.
`default_nettype none
module tip_counter_windowed_rate_top
#(
    parameter int RING_DEPTH = tcwr_pkg::RING_DEPTH_DEF
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_we,
    input  wire logic [1:0]  cfg_addr,
    input  wire logic [23:0] cfg_wdata,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [1:0]  command,
    input  wire logic [31:0] now_ms,
    input  wire logic        pin_level,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic [31:0]      edge_total,
    output logic [30:0]      tip_total,
    output logic [31:0]      last_edge_time,
    output logic             edge_accepted,
    output logic [47:0]      rainfall_ml,
    output logic [47:0]      rate_ml_per_min,
    output logic             depth_valid,
    output logic [47:0]      rainfall_mm,
    output logic [47:0]      rate_mm_per_hr
);
    localparam int AW = $clog2(RING_DEPTH);
    localparam logic [AW-1:0] LAST_IDX = AW'(RING_DEPTH - 1);
    localparam logic [AW:0]   FULL     = (AW+1)'(RING_DEPTH);

    // Sequencer codes. The walk reads one ring entry per pass through S_WRD and S_WCHK, then the
    // shared multiplier and divider produce the rate and the depth values.
    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_WRD  = 4'd1;
    localparam logic [3:0] S_WCHK = 4'd2;
    localparam logic [3:0] S_RCHK = 4'd3;
    localparam logic [3:0] S_OUTP = 4'd4;
    localparam logic [3:0] S_MLO  = 4'd5;
    localparam logic [3:0] S_MHI  = 4'd6;
    localparam logic [3:0] S_DIV  = 4'd7;
    localparam logic [3:0] S_DONE = 4'd8;

    // Which quantity the current division produces.
    localparam logic [1:0] JOB_RATE = 2'd0;
    localparam logic [1:0] JOB_RMM  = 2'd1;
    localparam logic [1:0] JOB_HMM  = 2'd2;

    logic [3:0]  state_reg, state_next;
    logic [1:0]  job_reg, job_next;

    // Configuration registers.
    logic [15:0] debounce_reg;
    logic [21:0] window_reg;
    logic [23:0] ml_reg;
    logic [23:0] area_reg;

    // Counter state.
    logic [31:0] edges_reg, edges_next;
    logic [31:0] stamp_reg, stamp_next;
    logic [31:0] dref_reg, dref_next;
    logic        level_reg, level_next;
    logic [AW-1:0] head_reg, head_next;
    logic [AW:0]   fill_reg, fill_next;
    logic [47:0] held_reg, held_next;

    // Latched command.
    logic [1:0]  cmd_reg, cmd_next;
    logic [31:0] now_reg, now_next;
    logic        acc_reg, acc_next;

    // Walk state.
    logic [AW-1:0] ptr_reg, ptr_next;
    logic [AW:0]   wcnt_reg, wcnt_next;
    logic [31:0] otime_reg, otime_next;
    logic [30:0] otips_reg, otips_next;

    // Arithmetic operands and partial results.
    logic [55:0] opa_reg, opa_next;
    logic [23:0] k_reg, k_next;
    logic [32:0] den_reg, den_next;
    logic [71:0] num_reg, num_next;
    logic [55:0] p2_reg, p2_next;
    logic [47:0] rmm_reg, rmm_next;
    logic [47:0] hmm_reg, hmm_next;

    // Output register.
    logic        ovalid_reg, ovalid_next;
    logic        oload;

    logic        in_xfer;
    logic [30:0] tips_cur;
    logic [31:0] mul_a;
    logic [23:0] mul_b;
    logic [55:0] prod;
    logic [31:0] dt;
    logic [31:0] delta;
    logic        ring_we;
    logic [62:0] ring_rdata;
    logic [31:0] rd_time;
    logic [30:0] rd_tips;
    logic        div_start;
    logic        div_done;
    logic [47:0] div_quot;

    assign in_ready = (state_reg == S_IDLE) && !ovalid_reg;
    assign in_xfer  = in_valid && in_ready;
    assign tips_cur = edges_reg[31:1];
    assign rd_time  = ring_rdata[31:0];
    assign rd_tips  = ring_rdata[62:32];
    assign dt       = now_reg - rd_time;
    assign delta    = now_reg - otime_reg;
    assign ring_we  = in_xfer && (command == tcwr_pkg::CMD_TICK);

    // The single shared multiplier: 32 x 24 bits.
    assign prod = mul_a * mul_b;

    tcwr_ring #(.DEPTH(RING_DEPTH)) u_ring
    (
        .clk   (clk),
        .we    (ring_we),
        .waddr (head_reg),
        .wdata ({edges_reg[31:1], now_ms}),
        .raddr (ptr_reg),
        .rdata (ring_rdata)
    );

    tcwr_div u_div
    (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (num_next),
        .den   (den_reg),
        .done  (div_done),
        .quot  (div_quot)
    );

    always_comb
    begin
        state_next  = state_reg;
        job_next    = job_reg;
        edges_next  = edges_reg;
        stamp_next  = stamp_reg;
        dref_next   = dref_reg;
        level_next  = level_reg;
        head_next   = head_reg;
        fill_next   = fill_reg;
        held_next   = held_reg;
        cmd_next    = cmd_reg;
        now_next    = now_reg;
        acc_next    = acc_reg;
        ptr_next    = ptr_reg;
        wcnt_next   = wcnt_reg;
        otime_next  = otime_reg;
        otips_next  = otips_reg;
        opa_next    = opa_reg;
        k_next      = k_reg;
        den_next    = den_reg;
        num_next    = num_reg;
        p2_next     = p2_reg;
        rmm_next    = rmm_reg;
        hmm_next    = hmm_reg;
        ovalid_next = ovalid_reg;
        oload       = 1'b0;
        div_start   = 1'b0;
        mul_a       = {1'b0, tips_cur};
        mul_b       = ml_reg;

        if (ovalid_reg && out_ready)
        begin
            ovalid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (in_xfer)
                begin
                    cmd_next   = command;
                    now_next   = now_ms;
                    acc_next   = 1'b0;
                    state_next = S_OUTP;
                    case (command)
                        tcwr_pkg::CMD_PIN:
                        begin
                            if ((pin_level != level_reg) &&
                                ((now_ms - dref_reg) >= {16'd0, debounce_reg}))
                            begin
                                level_next = pin_level;
                                dref_next  = now_ms;
                                edges_next = edges_reg + 1'b1;
                                stamp_next = now_ms;
                                acc_next   = 1'b1;
                            end
                        end
                        tcwr_pkg::CMD_TICK:
                        begin
                            // The new sample is written now; the walk starts on it.
                            ptr_next   = head_reg;
                            head_next  = (head_reg == LAST_IDX) ? '0 : head_reg + 1'b1;
                            if (fill_reg < FULL)
                            begin
                                fill_next = fill_reg + 1'b1;
                            end
                            wcnt_next  = '0;
                            otime_next = now_ms;
                            otips_next = edges_reg[31:1];
                            state_next = S_WRD;
                        end
                        tcwr_pkg::CMD_RESET:
                        begin
                            edges_next = '0;
                            stamp_next = '0;
                            dref_next  = '0;
                            level_next = pin_level;
                            head_next  = '0;
                            fill_next  = '0;
                            held_next  = '0;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end

            S_WRD:
            begin
                state_next = S_WCHK;
            end

            S_WCHK:
            begin
                // Keep walking toward older samples while they stay inside the window and filled entries remain.
                if (dt <= {10'd0, window_reg})
                begin
                    otime_next = rd_time;
                    otips_next = rd_tips;
                    wcnt_next  = wcnt_reg + 1'b1;
                    ptr_next   = (ptr_reg == '0) ? LAST_IDX : ptr_reg - 1'b1;
                    state_next = ((wcnt_reg + 1'b1) == fill_reg) ? S_RCHK : S_WRD;
                end
                else
                begin
                    state_next = S_RCHK;
                end
            end

            S_RCHK:
            begin
                if ((delta == '0) || (tips_cur < otips_reg))
                begin
                    held_next  = '0;
                    state_next = S_OUTP;
                end
                else
                begin
                    mul_a      = {1'b0, tips_cur - otips_reg};
                    opa_next   = prod;
                    k_next     = tcwr_pkg::K_RATE;
                    den_next   = {1'b0, delta};
                    job_next   = JOB_RATE;
                    state_next = S_MLO;
                end
            end

            S_OUTP:
            begin
                p2_next  = prod;
                rmm_next = '0;
                hmm_next = '0;
                if (area_reg == '0)
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    opa_next   = prod;
                    k_next     = tcwr_pkg::K_RAINMM;
                    den_next   = {9'd0, area_reg};
                    job_next   = JOB_RMM;
                    state_next = S_MLO;
                end
            end

            S_MLO:
            begin
                mul_a      = {4'd0, opa_reg[27:0]};
                mul_b      = k_reg;
                num_next   = {16'd0, prod};
                state_next = S_MHI;
            end

            S_MHI:
            begin
                mul_a      = {4'd0, opa_reg[55:28]};
                mul_b      = k_reg;
                num_next   = num_reg + ({16'd0, prod} << 28);
                div_start  = 1'b1;
                state_next = S_DIV;
            end

            S_DIV:
            begin
                if (div_done)
                begin
                    case (job_reg)
                        JOB_RATE:
                        begin
                            held_next  = div_quot;
                            state_next = S_OUTP;
                        end
                        JOB_RMM:
                        begin
                            rmm_next   = div_quot;
                            opa_next   = {8'd0, held_reg};
                            k_next     = tcwr_pkg::K_RATEMM;
                            job_next   = JOB_HMM;
                            state_next = S_MLO;
                        end
                        default:
                        begin
                            hmm_next   = div_quot;
                            state_next = S_DONE;
                        end
                    endcase
                end
            end

            S_DONE:
            begin
                oload       = 1'b1;
                ovalid_next = 1'b1;
                state_next  = S_IDLE;
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            job_reg      <= JOB_RATE;
            debounce_reg <= 16'd50;
            window_reg   <= 22'd60000;
            ml_reg       <= 24'd327680;
            area_reg     <= '0;
            edges_reg    <= '0;
            stamp_reg    <= '0;
            dref_reg     <= '0;
            level_reg    <= 1'b1;
            head_reg     <= '0;
            fill_reg     <= '0;
            held_reg     <= '0;
            ovalid_reg   <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            job_reg    <= job_next;
            edges_reg  <= edges_next;
            stamp_reg  <= stamp_next;
            dref_reg   <= dref_next;
            level_reg  <= level_next;
            head_reg   <= head_next;
            fill_reg   <= fill_next;
            held_reg   <= held_next;
            ovalid_reg <= ovalid_next;
            if (cfg_we)
            begin
                case (cfg_addr)
                    tcwr_pkg::REG_DEBOUNCE: debounce_reg <= cfg_wdata[15:0];
                    tcwr_pkg::REG_WINDOW:   window_reg   <= cfg_wdata[21:0];
                    tcwr_pkg::REG_ML:       ml_reg       <= cfg_wdata;
                    tcwr_pkg::REG_AREA:     area_reg     <= cfg_wdata;
                    default:
                    begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg   <= cmd_next;
        now_reg   <= now_next;
        acc_reg   <= acc_next;
        ptr_reg   <= ptr_next;
        wcnt_reg  <= wcnt_next;
        otime_reg <= otime_next;
        otips_reg <= otips_next;
        opa_reg   <= opa_next;
        k_reg     <= k_next;
        den_reg   <= den_next;
        num_reg   <= num_next;
        p2_reg    <= p2_next;
        rmm_reg   <= rmm_next;
        hmm_reg   <= hmm_next;
        if (oload)
        begin
            edge_total      <= edges_reg;
            tip_total       <= tips_cur;
            last_edge_time  <= stamp_reg;
            edge_accepted   <= acc_reg && (cmd_reg == tcwr_pkg::CMD_PIN);
            rainfall_ml     <= (|p2_reg[55:48]) ? tcwr_pkg::SAT48 : p2_reg[47:0];
            rate_ml_per_min <= held_reg;
            depth_valid     <= (area_reg != '0);
            rainfall_mm     <= rmm_reg;
            rate_mm_per_hr  <= hmm_reg;
        end
    end

    assign out_valid = ovalid_reg;
endmodule
`default_nettype wire
